@@ rtl/core/csvt_pkg.sv @@
// csvt_pkg: shared types and constants of the CSV field tokenizer.
// Used by the step logic, the result queue and the top level.
`default_nettype none

package csvt_pkg;

  // Character codes the parser tests for
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;

  // Reset value of the delimiter register (comma)
  localparam logic [7:0] DELIM_RESET = 8'd44;

  // Default depth of the result queue
  localparam int OUTQ_DEPTH = 4;

  // Register address decode
  localparam int CFG_AW   = 3;
  localparam logic REG_DELIM = 1'b0;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_FIELD = 2'd1,
    KIND_ROW   = 2'd2
  } kind_t;

  // One result item
  typedef struct packed {
    kind_t       kind;
    logic [7:0]  data_byte;
    logic        last;
  } result_t;

  // Parser flags
  typedef struct packed {
    logic in_quotes;
    logic quote_pending;
    logic cr_pending;
    logic row_saw_content;
    logic field_has_bytes;
    logic row_has_fields;
  } state_t;

  // Results of one item, handed to the queue
  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } push_t;

endpackage

`default_nettype wire

@@ rtl/core/csvt_if.sv @@
// csvt_if: valid/ready stream interfaces for text items and result items.
// Does not depend on csvt_pkg; its widths are fixed here.
`default_nettype none

interface csvt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

interface csvt_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, output kind, output data_byte, output last, input ready);
  modport sink   (input valid, input kind, input data_byte, input last, output ready);
endinterface

`default_nettype wire

@@ rtl/core/csv_field_tokenizer.sv @@
// csv_field_tokenizer: top level, delimiter register, parser flags and queue.
// Depends on csvt_pkg, csvt_if, csvt_step and csvt_outq.
`default_nettype none

// Streaming CSV tokenizer. Each input item is one text byte, or an end-of-text
// mark, and is parsed in the cycle it is accepted; its zero, one or two
// result items (data byte, end of field, end of field and row) go into a
// queue of OUTQ_DEPTH entries in front of the output channel. An input item
// is taken every cycle while the queue has room for two results, so the
// block runs at one item per cycle; the output port delivers one result per
// cycle while ready, so items that cause two results (a lone CR followed
// by a byte) drain at that rate. The delimiter register sits at byte address 0
// of the APB port and should only be written while the block is idle.
module csv_field_tokenizer #(
  parameter int OUTQ_DEPTH = csvt_pkg::OUTQ_DEPTH
) (
  input  logic                        clk,
  input  logic                        rst_n,
  csvt_in_if.sink                     in_chan,
  csvt_out_if.source                  out_chan,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [csvt_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  logic [7:0]       delim_r;
  csvt_pkg::state_t state_r, state_nxt;
  csvt_pkg::push_t  step_push;
  csvt_pkg::push_t  push;
  logic             room;
  logic             in_fire;
  logic             cfg_wr;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == csvt_pkg::REG_DELIM) ? {24'h0, delim_r} : 32'h0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r <= csvt_pkg::DELIM_RESET;
    end else if (cfg_wr && cfg_paddr[2] == csvt_pkg::REG_DELIM) begin
      delim_r <= cfg_pwdata[7:0];
    end
  end

  // input handshake
  assign in_chan.ready = room;
  assign in_fire       = in_chan.valid & room;

  csvt_step u_step (
    .state_i (state_r),
    .delim_i (delim_r),
    .char_i  (in_chan.char_code),
    .eot_i   (in_chan.end_of_text),
    .state_o (state_nxt),
    .push_o  (step_push)
  );

  // only accepted items push results
  always_comb begin
    push = step_push;
    if (!in_fire) begin
      push.count = 2'd0;
    end
  end

  // parser flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (in_fire) begin
      state_r <= state_nxt;
    end
  end

  csvt_outq #(
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_i   (push),
    .room_o   (room),
    .out_chan (out_chan)
  );

`ifndef SYNTHESIS
  a_eot_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_chan.end_of_text |=> state_r == '0)
    else $error("parser flags not cleared after end of text");

  a_qp_in_quotes: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.quote_pending |-> state_r.in_quotes)
    else $error("quote pending outside quoted field");

  a_cr_unquoted: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.cr_pending |-> !state_r.in_quotes)
    else $error("CR pending inside quoted field");

  a_last_marks: assert property (@(posedge clk) disable iff (!rst_n)
    push.count == 2'd2 |-> !push.res0.last && push.res1.last)
    else $error("last flag misplaced on two-result item");
`endif

endmodule

`default_nettype wire

@@ rtl/core/csvt_step.sv @@
// csvt_step: combinational parse of one text item against the parser flags.
// Gives the next flags and up to two result items. Depends on csvt_pkg.
`default_nettype none

module csvt_step (
  input  csvt_pkg::state_t state_i,
  input  logic [7:0]       delim_i,
  input  logic [7:0]       char_i,
  input  logic             eot_i,
  output csvt_pkg::state_t state_o,
  output csvt_pkg::push_t  push_o
);

  csvt_pkg::state_t  st;
  csvt_pkg::result_t a;
  csvt_pkg::result_t b;
  logic              a_v;
  logic              b_v;
  logic              plain_en;

  always_comb begin
    st       = state_i;
    a_v      = 1'b0;
    b_v      = 1'b0;
    a        = '{kind: csvt_pkg::KIND_DATA, data_byte: 8'h00, last: 1'b0};
    b        = '{kind: csvt_pkg::KIND_DATA, data_byte: 8'h00, last: 1'b0};
    plain_en = 1'b0;

    if (eot_i) begin
      // end of text: a pending CR or any content flushes one row
      a_v    = state_i.cr_pending | state_i.row_saw_content |
               state_i.field_has_bytes | state_i.row_has_fields;
      a.kind = csvt_pkg::KIND_ROW;
      st     = '0;
    end else begin
      plain_en = 1'b1;
      // resolve the one-byte lookahead first
      if (st.quote_pending) begin
        st.quote_pending = 1'b0;
        if (char_i == csvt_pkg::CH_QUOTE) begin
          // doubled quote inside a quoted field
          a_v                = 1'b1;
          a.data_byte        = csvt_pkg::CH_QUOTE;
          st.field_has_bytes = 1'b1;
          plain_en           = 1'b0;
        end else begin
          st.in_quotes = 1'b0;
        end
      end else if (st.cr_pending) begin
        st.cr_pending = 1'b0;
        if (char_i != csvt_pkg::CH_LF) begin
          // lone CR ends the row
          a_v                = 1'b1;
          a.kind             = csvt_pkg::KIND_ROW;
          st.row_saw_content = 1'b0;
          st.field_has_bytes = 1'b0;
          st.row_has_fields  = 1'b0;
        end
      end

      // ordinary byte handling
      if (plain_en) begin
        if (st.in_quotes) begin
          if (char_i == csvt_pkg::CH_QUOTE) begin
            st.quote_pending = 1'b1;
          end else begin
            b_v                = 1'b1;
            b.data_byte        = char_i;
            st.field_has_bytes = 1'b1;
          end
        end else if (char_i == csvt_pkg::CH_QUOTE) begin
          st.in_quotes       = 1'b1;
          st.row_saw_content = 1'b1;
        end else if (char_i == delim_i) begin
          b_v                = 1'b1;
          b.kind             = csvt_pkg::KIND_FIELD;
          st.row_saw_content = 1'b1;
          st.row_has_fields  = 1'b1;
          st.field_has_bytes = 1'b0;
        end else if (char_i == csvt_pkg::CH_LF) begin
          b_v                = 1'b1;
          b.kind             = csvt_pkg::KIND_ROW;
          st.row_saw_content = 1'b0;
          st.field_has_bytes = 1'b0;
          st.row_has_fields  = 1'b0;
        end else if (char_i == csvt_pkg::CH_CR) begin
          st.cr_pending = 1'b1;
        end else begin
          b_v                = 1'b1;
          b.data_byte        = char_i;
          st.row_saw_content = 1'b1;
          st.field_has_bytes = 1'b1;
        end
      end
    end

    // pack: lookahead result first, then the byte's own result
    a.last = ~b_v;
    b.last = 1'b1;
    state_o      = st;
    push_o.count = {a_v & b_v, a_v ^ b_v};
    push_o.res0  = a_v ? a : b;
    push_o.res1  = b;
  end

endmodule

`default_nettype wire

@@ rtl/core/csvt_outq.sv @@
// csvt_outq: small result queue, takes up to two items a cycle, gives one while the output is ready.
// Depends on csvt_pkg and csvt_out_if.
`default_nettype none

module csvt_outq #(
  parameter int DEPTH = csvt_pkg::OUTQ_DEPTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  csvt_pkg::push_t   push_i,
  output logic              room_o,
  csvt_out_if.source        out_chan
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  csvt_pkg::result_t mem_r [DEPTH];
  logic [PW-1:0]     wr_ptr_r, wr_ptr_nxt, wr_ptr1;
  logic [PW-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic              pop;
  csvt_pkg::result_t head;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    ptr_inc = (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
  endfunction

  assign wr_ptr1 = ptr_inc(wr_ptr_r);
  assign pop     = out_chan.valid & out_chan.ready;
  // space for the worst-case two results of one item
  assign room_o  = (count_r <= CW'(DEPTH - 2));

  // pointer and fill bookkeeping
  always_comb begin
    case (push_i.count)
      2'd1:    wr_ptr_nxt = wr_ptr1;
      2'd2:    wr_ptr_nxt = ptr_inc(wr_ptr1);
      default: wr_ptr_nxt = wr_ptr_r;
    endcase
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CW'(push_i.count) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage, no reset needed
  always_ff @(posedge clk) begin
    if (push_i.count != 2'd0) begin
      mem_r[wr_ptr_r] <= push_i.res0;
    end
    if (push_i.count == 2'd2) begin
      mem_r[wr_ptr1] <= push_i.res1;
    end
  end

  assign head               = mem_r[rd_ptr_r];
  assign out_chan.valid     = (count_r != '0);
  assign out_chan.kind      = head.kind;
  assign out_chan.data_byte = (head.kind == csvt_pkg::KIND_DATA) ? head.data_byte : 8'h00;
  assign out_chan.last      = head.last;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("result queue overfilled");

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !room_o |-> push_i.count == 2'd0)
    else $error("push into result queue without room");
`endif

endmodule

`default_nettype wire

@@ test/tb_top.sv @@
// tb_top: self-checking bench for csv_field_tokenizer; a directed byte table, then random
// CSV texts under several delimiters and handshake stall patterns, checked by a local parser.
// Depends on csvt_pkg, csvt_if and the csv_field_tokenizer RTL.
`default_nettype none

module tb_top;
  import csvt_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int PHASE_ITEMS = 72;
  localparam logic [CFG_AW-1:0] DELIM_ADDR = {REG_DELIM, 2'b00};

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic cfg_pready;

  csvt_in_if  in_ch ();
  csvt_out_if out_ch ();

  csv_field_tokenizer uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_ch),
    .out_chan    (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Clock: 10 units
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Parser mirror: delimiter and flags
  logic [7:0] delim_q = DELIM_RESET;
  bit quoted, quote_wait, cr_wait, row_content, field_bytes, row_fields;
  result_t step_res [2];
  int step_n;

  result_t pending_tokens [$];
  int fail_count = 0;
  int stall_cycles = 0;
  int send_idle = 0;
  int recv_stall = 0;

  // Expectation typed in by the directed table, carried with the item
  bit drv_typed = 1'b0;
  int drv_n;
  result_t drv_r0, drv_r1;

  typedef struct {
    logic [7:0] ch;
    logic       eot;
    bit         typed;
    int         n;
    result_t    r0;
    result_t    r1;
  } dir_row_t;

  dir_row_t dir_rows [$];
  logic [7:0] text_bytes [$];

  // Append to the expected-result queue
  function void queue_token(result_t t);
    pending_tokens = {pending_tokens, t};
  endfunction

  // Append one byte to the text being built
  function void append_byte(logic [7:0] v);
    text_bytes = {text_bytes, v};
  endfunction

  function void put_token(kind_t k, logic [7:0] b);
    if (step_n < 2) begin
      step_res[step_n].kind = k;
      step_res[step_n].data_byte = b;
      step_res[step_n].last = 1'b0;
      step_n++;
    end
  endfunction

  function void close_row();
    put_token(KIND_ROW, 8'h00);
    row_content = 1'b0;
    field_bytes = 1'b0;
    row_fields = 1'b0;
  endfunction

  // Byte outside of any pending quote or CR
  function void plain_char(logic [7:0] c);
    if (quoted) begin
      if (c == CH_QUOTE) begin
        quote_wait = 1'b1;
      end else begin
        put_token(KIND_DATA, c);
        field_bytes = 1'b1;
      end
    end else if (c == CH_QUOTE) begin
      quoted = 1'b1;
      row_content = 1'b1;
    end else if (c == delim_q) begin
      put_token(KIND_FIELD, 8'h00);
      row_content = 1'b1;
      row_fields = 1'b1;
      field_bytes = 1'b0;
    end else if (c == CH_LF) begin
      close_row();
    end else if (c == CH_CR) begin
      cr_wait = 1'b1;
    end else begin
      put_token(KIND_DATA, c);
      row_content = 1'b1;
      field_bytes = 1'b1;
    end
  endfunction

  // Tokens caused by one accepted item, left in step_res/step_n
  function void tokenize_byte(logic [7:0] c, logic eot);
    step_n = 0;
    if (eot) begin
      if (quote_wait) begin
        quote_wait = 1'b0;
        quoted = 1'b0;
      end
      if (cr_wait) begin
        cr_wait = 1'b0;
        close_row();
      end
      if (row_content || field_bytes || row_fields) close_row();
      quoted = 1'b0;
      quote_wait = 1'b0;
      cr_wait = 1'b0;
      row_content = 1'b0;
      field_bytes = 1'b0;
      row_fields = 1'b0;
    end else if (quote_wait) begin
      quote_wait = 1'b0;
      if (c == CH_QUOTE) begin
        put_token(KIND_DATA, CH_QUOTE);
        field_bytes = 1'b1;
      end else begin
        quoted = 1'b0;
        plain_char(c);
      end
    end else if (cr_wait) begin
      cr_wait = 1'b0;
      if (c != CH_LF) close_row();
      plain_char(c);
    end else begin
      plain_char(c);
    end
    if (step_n > 0) step_res[step_n-1].last = 1'b1;
  endfunction

  // Monitor: predict on input accept, check on output accept
  always @(posedge clk) begin
    result_t want;
    bit in_fire, out_fire;
    if (rst_n) begin
      in_fire = in_ch.valid && in_ch.ready;
      out_fire = out_ch.valid && out_ch.ready;
      if (in_fire) begin
        tokenize_byte(in_ch.char_code, in_ch.end_of_text);
        if (drv_typed) begin
          if (drv_n > 0) queue_token(drv_r0);
          if (drv_n > 1) queue_token(drv_r1);
        end else begin
          for (int i = 0; i < step_n; i++) queue_token(step_res[i]);
        end
      end
      if (out_fire) begin
        if (pending_tokens.size() == 0) begin
          $error("unexpected item: kind %0d data_byte %02h last %0d",
                 out_ch.kind, out_ch.data_byte, out_ch.last);
          fail_count++;
        end else begin
          want = pending_tokens.pop_front();
          if (out_ch.kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, out_ch.kind);
            fail_count++;
          end
          if (out_ch.data_byte !== want.data_byte) begin
            $error("data_byte: expected %02h, got %02h", want.data_byte, out_ch.data_byte);
            fail_count++;
          end
          if (out_ch.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, out_ch.last);
            fail_count++;
          end
        end
      end
      stall_cycles = (in_fire || out_fire) ? 0 : stall_cycles + 1;
    end
  end

  // Watchdog on cycles with no traffic
  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("RESULT: ERROR");
    $finish;
  end

  // Result side back-pressure
  always @(negedge clk) begin
    out_ch.ready = ($urandom_range(0, 99) >= recv_stall);
  end

  task automatic send_item(input logic [7:0] ch, input logic eot);
    while ($urandom_range(0, 99) < send_idle) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.char_code = ch;
    in_ch.end_of_text = eot;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Hold input until all results are out, then let the block go quiet
  task automatic settle();
    in_ch.valid = 1'b0;
    while (pending_tokens.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Optional write of the delimiter, then a read-back
  task automatic set_delimiter(input logic [7:0] val, input bit do_write);
    if (do_write) begin
      cfg_psel = 1'b1;
      cfg_penable = 1'b0;
      cfg_pwrite = 1'b1;
      cfg_paddr = DELIM_ADDR;
      cfg_pwdata = {24'd0, val};
      @(negedge clk);
      cfg_penable = 1'b1;
      do @(posedge clk); while (!cfg_pready);
      delim_q = val;
      @(negedge clk);
    end
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = DELIM_ADDR;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata[7:0] !== delim_q) begin
      $error("delimiter: expected %02h, got %02h", delim_q, cfg_prdata[7:0]);
      fail_count++;
    end
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
  endtask

  task automatic add_row(input logic [7:0] ch, input logic eot, input bit typed, input int n,
                         input kind_t k0 = KIND_DATA, input logic [7:0] b0 = 8'h00,
                         input kind_t k1 = KIND_DATA, input logic [7:0] b1 = 8'h00);
    dir_row_t r;
    r.ch = ch;
    r.eot = eot;
    r.typed = typed;
    r.n = n;
    r.r0.kind = k0;
    r.r0.data_byte = b0;
    r.r0.last = (n == 1);
    r.r1.kind = k1;
    r.r1.data_byte = b1;
    r.r1.last = 1'b1;
    dir_rows = {dir_rows, r};
  endtask

  // Mostly well-formed CSV text with random content; some noise and corruption
  task automatic build_text();
    int rows, fields, len;
    logic [7:0] b;
    text_bytes.delete();
    if ($urandom_range(0, 9) == 0) begin
      len = $urandom_range(1, 12);
      repeat (len) append_byte(8'($urandom_range(0, 255)));
      return;
    end
    rows = $urandom_range(1, 3);
    for (int r = 0; r < rows; r++) begin
      fields = $urandom_range(1, 4);
      for (int f = 0; f < fields; f++) begin
        if (f > 0) append_byte(delim_q);
        len = $urandom_range(0, 4);
        if ($urandom_range(0, 2) == 0) begin
          // quoted field: separators, line breaks and doubled quotes inside
          append_byte(CH_QUOTE);
          repeat (len) begin
            case ($urandom_range(0, 5))
              0: append_byte(delim_q);
              1: append_byte(CH_CR);
              2: append_byte(CH_LF);
              default: begin
                b = 8'($urandom_range(0, 255));
                if (b == CH_QUOTE) append_byte(CH_QUOTE);
                append_byte(b);
              end
            endcase
          end
          append_byte(CH_QUOTE);
        end else begin
          repeat (len) begin
            b = 8'($urandom_range(0, 255));
            if (b == CH_QUOTE || b == delim_q || b == CH_CR || b == CH_LF) b = 8'h61;
            append_byte(b);
          end
        end
      end
      // row end: LF, CRLF, lone CR, or none on the last row
      case ((r == rows - 1) ? $urandom_range(0, 3) : $urandom_range(0, 2))
        0: append_byte(CH_LF);
        1: begin
          append_byte(CH_CR);
          append_byte(CH_LF);
        end
        2: append_byte(CH_CR);
        default: ;
      endcase
    end
    if ($urandom_range(0, 7) == 0 && text_bytes.size() > 0)
      text_bytes[$urandom_range(0, text_bytes.size() - 1)] = 8'($urandom_range(0, 255));
  endtask

  // Stimulus
  initial begin
    logic [7:0] phase_delim [8] = '{8'd44, 8'h09, 8'h00, 8'hFF, CH_QUOTE, CH_LF, CH_CR, 8'h3B};
    int sent;
    bit drained;
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.char_code = 8'h00;
    in_ch.end_of_text = 1'b0;
    out_ch.ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = 32'd0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed table, default comma delimiter
    add_row(8'h61, 1'b0, 1'b1, 1, KIND_DATA, 8'h61);
    add_row(8'h2C, 1'b0, 1'b1, 1, KIND_FIELD);
    add_row(8'hFF, 1'b0, 1'b1, 1, KIND_DATA, 8'hFF);
    add_row(8'h00, 1'b0, 1'b1, 1, KIND_DATA, 8'h00);
    add_row(CH_QUOTE, 1'b0, 1'b1, 0);                  // quote in unquoted field opens quotes
    add_row(8'h2C, 1'b0, 1'b1, 1, KIND_DATA, 8'h2C);   // delimiter is content
    add_row(CH_LF, 1'b0, 1'b1, 1, KIND_DATA, CH_LF);
    add_row(CH_QUOTE, 1'b0, 1'b1, 0);
    add_row(CH_QUOTE, 1'b0, 1'b1, 1, KIND_DATA, CH_QUOTE); // doubled quote
    add_row(CH_QUOTE, 1'b0, 1'b1, 0);
    add_row(8'h62, 1'b0, 1'b0, 0);                     // text after closing quote
    add_row(CH_CR, 1'b0, 1'b1, 0);
    add_row(CH_LF, 1'b0, 1'b1, 1, KIND_ROW);           // CRLF is one row end
    add_row(CH_CR, 1'b0, 1'b1, 0);
    add_row(8'h78, 1'b0, 1'b0, 0);                     // lone CR then a byte
    add_row(CH_CR, 1'b0, 1'b1, 0);
    add_row(8'hFF, 1'b1, 1'b1, 1, KIND_ROW);           // CR at end of text
    add_row(8'h00, 1'b1, 1'b1, 0);                     // empty text
    add_row(CH_QUOTE, 1'b0, 1'b1, 0);
    add_row(8'h71, 1'b0, 1'b1, 1, KIND_DATA, 8'h71);
    add_row(8'h55, 1'b1, 1'b1, 1, KIND_ROW);           // unterminated quote
    add_row(CH_LF, 1'b0, 1'b1, 1, KIND_ROW);           // empty row
    add_row(CH_QUOTE, 1'b0, 1'b1, 0);
    add_row(CH_QUOTE, 1'b0, 1'b1, 0);
    add_row(8'hAA, 1'b1, 1'b1, 1, KIND_ROW);           // closing quote at end of text
    foreach (dir_rows[i]) begin
      drv_typed = dir_rows[i].typed;
      drv_n = dir_rows[i].n;
      drv_r0 = dir_rows[i].r0;
      drv_r1 = dir_rows[i].r1;
      send_item(dir_rows[i].ch, dir_rows[i].eot);
    end
    drv_typed = 1'b0;
    settle();

    // Random texts: one delimiter and one stall pattern per phase
    for (int p = 0; p < 8; p++) begin
      case (p % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 69; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 69; end
        default: begin send_idle = 8; recv_stall = 8; end
      endcase
      set_delimiter(phase_delim[p], p > 0);
      sent = 0;
      drained = 1'b0;
      while (sent < PHASE_ITEMS) begin
        build_text();
        foreach (text_bytes[i]) send_item(text_bytes[i], 1'b0);
        send_item(8'($urandom_range(0, 255)), 1'b1);
        sent += text_bytes.size() + 1;
        // mid-phase, let the result side catch up fully
        if (!drained && sent >= PHASE_ITEMS / 2) begin
          in_ch.valid = 1'b0;
          while (pending_tokens.size() != 0) @(negedge clk);
          drained = 1'b1;
        end
      end
      settle();
    end

    repeat (4) @(posedge clk);
    if (fail_count == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire

@@ filelist.f @@
rtl/core/csvt_pkg.sv
rtl/core/csvt_if.sv
rtl/core/csvt_step.sv
rtl/core/csvt_outq.sv
rtl/core/csv_field_tokenizer.sv
test/tb_top.sv
